>>> rtl/core/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/lzrle_pkg.sv
// package with window constants, state types and control structs of the decoder
`timescale 1ns / 1ps

package lzrle_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW = $clog2(WINDOW_DEPTH);
  localparam logic [WIN_AW-1:0] WIN_LAST = WIN_AW'(WINDOW_DEPTH - 1);
  localparam logic [WIN_AW:0] WIN_DEPTH_X = (WIN_AW + 1)'(WINDOW_DEPTH);

  localparam logic [3:0] LEN_MASK = 4'hf;
  localparam logic [6:0] RUN_BIAS = 7'd62;
  localparam logic [6:0] RUN_MIN = 7'd2;
  localparam logic [6:0] RUN_MAX = 7'd65;
  localparam logic [12:0] DIST_BASE = 13'h1001;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RUN_FILL,
    S_COPY_RD,
    S_COPY_WR
  } state_t;

  typedef enum logic [1:0] {
    P_TOKEN = 2'd0,
    P_REF   = 2'd1,
    P_LIT   = 2'd2,
    P_RUN   = 2'd3
  } phase_t;

  typedef struct packed {
    logic accept;
    logic tok_held;
    logic tok_pending;
    logic ref_setup;
    logic lit_emit;
    logic run_emit;
    logic run_fill;
    logic copy_read;
    logic copy_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] token_class;
    logic       pending_last;
    logic       run_last;
    logic       copy_last;
    logic       out_free;
  } ctrl_sts_t;

endpackage

>>> rtl/core/lzrle_if.sv
// stream interfaces for compressed input and decoded output
`timescale 1ns / 1ps

interface lzrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_stream;

  modport source(output valid, in_byte, start_of_stream, input ready);
  modport sink(input valid, in_byte, start_of_stream, output ready);
endinterface

interface lzrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [6:0] repeat_res;
  logic       last_of_run;

  modport source(output valid, out_byte, repeat_res, last_of_run, input ready);
  modport sink(input valid, out_byte, repeat_res, last_of_run, output ready);
endinterface

>>> rtl/core/lzrle_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lzrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lzrle_ctrl.sv
// controller state machine: parser phase and sequencing of copies and runs
`timescale 1ns / 1ps

module lzrle_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  start_of_stream,
  input  lzrle_pkg::ctrl_sts_t  sts,
  output lzrle_pkg::ctrl_cmd_t  cmd,
  output logic                  in_ready
);

  lzrle_pkg::state_t state, state_next;
  lzrle_pkg::phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzrle_pkg::S_IDLE;
      phase <= lzrle_pkg::P_TOKEN;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      lzrle_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = lzrle_pkg::S_DECODE;
          if (start_of_stream) begin
            phase_next = lzrle_pkg::P_TOKEN;
          end
        end
      end
      lzrle_pkg::S_DECODE: begin
        unique case (phase)
          lzrle_pkg::P_TOKEN: begin
            state_next = lzrle_pkg::S_IDLE;
            if (sts.token_class[1]) begin
              phase_next = lzrle_pkg::P_REF;
            end else if (sts.token_class[0]) begin
              phase_next = lzrle_pkg::P_RUN;
            end else begin
              phase_next = lzrle_pkg::P_LIT;
            end
          end
          lzrle_pkg::P_REF: begin
            state_next = lzrle_pkg::S_COPY_RD;
            phase_next = lzrle_pkg::P_TOKEN;
          end
          lzrle_pkg::P_LIT: begin
            if (sts.out_free) begin
              state_next = lzrle_pkg::S_IDLE;
              if (sts.pending_last) begin
                phase_next = lzrle_pkg::P_TOKEN;
              end
            end
          end
          lzrle_pkg::P_RUN: begin
            if (sts.out_free) begin
              state_next = lzrle_pkg::S_RUN_FILL;
              phase_next = lzrle_pkg::P_TOKEN;
            end
          end
          default: begin
            state_next = lzrle_pkg::S_IDLE;
          end
        endcase
      end
      lzrle_pkg::S_RUN_FILL: begin
        if (sts.run_last) begin
          state_next = lzrle_pkg::S_IDLE;
        end
      end
      lzrle_pkg::S_COPY_RD: begin
        state_next = lzrle_pkg::S_COPY_WR;
      end
      lzrle_pkg::S_COPY_WR: begin
        if (sts.out_free) begin
          state_next = sts.copy_last ? lzrle_pkg::S_IDLE : lzrle_pkg::S_COPY_RD;
        end
      end
      default: begin
        state_next = lzrle_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      lzrle_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      lzrle_pkg::S_DECODE: begin
        unique case (phase)
          lzrle_pkg::P_TOKEN: begin
            cmd.tok_held = sts.token_class != 2'b00;
            cmd.tok_pending = sts.token_class == 2'b00;
          end
          lzrle_pkg::P_REF: begin
            cmd.ref_setup = 1'b1;
          end
          lzrle_pkg::P_LIT: begin
            cmd.lit_emit = sts.out_free;
          end
          lzrle_pkg::P_RUN: begin
            cmd.run_emit = sts.out_free;
          end
          default: begin
            cmd = '0;
          end
        endcase
      end
      lzrle_pkg::S_RUN_FILL: begin
        cmd.run_fill = 1'b1;
      end
      lzrle_pkg::S_COPY_RD: begin
        cmd.copy_read = 1'b1;
      end
      lzrle_pkg::S_COPY_WR: begin
        cmd.copy_write = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/lzrle_datapath.sv
// datapath: parser registers, window pointers, history ram and output register
`timescale 1ns / 1ps

module lzrle_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  lzrle_pkg::ctrl_cmd_t  cmd,
  output lzrle_pkg::ctrl_sts_t  sts,
  input  logic [7:0]            in_byte,
  input  logic                  start_of_stream,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            out_byte,
  output logic [6:0]            repeat_res,
  output logic                  last_of_run
);

  localparam int AW = lzrle_pkg::WIN_AW;

  logic [7:0]    byte_q;
  logic [6:0]    pending;
  logic [7:0]    held;
  logic [AW-1:0] wp;
  logic [AW-1:0] rd;
  logic [4:0]    copy_left;
  logic [6:0]    run_left;

  logic [11:0]   raw;
  logic [11:0]   span;
  logic [AW:0]   wp_x;
  logic [AW:0]   span_x;
  logic [AW-1:0] rd_start;
  logic [6:0]    run_raw;
  logic [6:0]    run_cnt;
  logic          hist_we;
  logic [7:0]    hist_wdata;
  logic [7:0]    hist_rdata;

  function automatic logic [AW-1:0] win_inc(input logic [AW-1:0] p);
    return (p == lzrle_pkg::WIN_LAST) ? '0 : p + 1'b1;
  endfunction

  // back-reference start address, wrapped into the window
  always_comb begin
    raw = {held, byte_q[7:4]};
    span = 12'(lzrle_pkg::DIST_BASE - {1'b0, raw});
    wp_x = {1'b0, wp};
    span_x = (AW + 1)'(span);
    if (wp_x >= span_x) begin
      rd_start = AW'(wp_x - span_x);
    end else begin
      rd_start = AW'(wp_x + lzrle_pkg::WIN_DEPTH_X - span_x);
    end
  end

  always_comb begin
    run_raw = held[6:0] - lzrle_pkg::RUN_BIAS;
    if (run_raw > lzrle_pkg::RUN_MAX || run_raw < lzrle_pkg::RUN_MIN) begin
      run_cnt = lzrle_pkg::RUN_MIN;
    end else begin
      run_cnt = run_raw;
    end
  end

  assign hist_we = cmd.lit_emit | cmd.run_fill | cmd.copy_write;
  assign hist_wdata = cmd.copy_write ? hist_rdata : byte_q;

  lzrle_ram #(
    .WIDTH(8),
    .DEPTH(lzrle_pkg::WINDOW_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (hist_we),
    .waddr(wp),
    .wdata(hist_wdata),
    .re   (cmd.copy_read),
    .raddr(rd),
    .rdata(hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending <= '0;
      held <= '0;
      wp <= '0;
    end else begin
      if (cmd.lit_emit || cmd.run_emit || cmd.copy_write) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept && start_of_stream) begin
        pending <= '0;
        held <= '0;
        wp <= '0;
      end
      if (cmd.tok_held) begin
        held <= byte_q;
      end
      if (cmd.tok_pending) begin
        pending <= {1'b0, byte_q[5:0]} + 7'd1;
      end
      if (cmd.ref_setup) begin
        held <= '0;
      end
      if (cmd.lit_emit) begin
        if (pending != '0) begin
          pending <= pending - 7'd1;
        end
      end
      if (cmd.run_emit) begin
        held <= '0;
      end
      if (hist_we) begin
        wp <= win_inc(wp);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q <= in_byte;
    end
    if (cmd.ref_setup) begin
      rd <= rd_start;
      copy_left <= {1'b0, byte_q[3:0] & lzrle_pkg::LEN_MASK} + 5'd2;
    end
    if (cmd.copy_write) begin
      rd <= win_inc(rd);
      copy_left <= copy_left - 5'd1;
      out_byte <= hist_rdata;
      repeat_res <= 7'd1;
      last_of_run <= copy_left == 5'd1;
    end
    if (cmd.lit_emit) begin
      out_byte <= byte_q;
      repeat_res <= 7'd1;
      last_of_run <= 1'b1;
    end
    if (cmd.run_emit) begin
      run_left <= run_cnt;
      out_byte <= byte_q;
      repeat_res <= run_cnt;
      last_of_run <= 1'b1;
    end
    if (cmd.run_fill) begin
      run_left <= run_left - 7'd1;
    end
  end

  always_comb begin
    sts.token_class = byte_q[7:6];
    sts.pending_last = pending <= 7'd1;
    sts.run_last = run_left == 7'd1;
    sts.copy_last = copy_left == 5'd1;
    sts.out_free = !out_valid || out_ready;
  end

endmodule

>>> rtl/core/lz_rle_byte_decompressor_core.sv
// top level of the byte stream decoder for back-references, literals and runs
// ready drops after each transfer until the byte and any run fill or copy are done
// literal: result registered in the decode state once the output is free
// run of n: result registered once the output is free, then n window fill writes
// back-reference of length L: per byte a window ram read, then a write and an output
// synchronous reset clears parser and window pointer; window ram content is kept
`timescale 1ns / 1ps

module lz_rle_byte_decompressor_core (
  input  logic         clk,
  input  logic         rst,
  lzrle_in_if.sink     compressed,
  lzrle_out_if.source  decoded
);

  lzrle_pkg::ctrl_cmd_t cmd;
  lzrle_pkg::ctrl_sts_t sts;

  lzrle_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (compressed.valid),
    .start_of_stream(compressed.start_of_stream),
    .sts            (sts),
    .cmd            (cmd),
    .in_ready       (compressed.ready)
  );

  lzrle_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_byte        (compressed.in_byte),
    .start_of_stream(compressed.start_of_stream),
    .out_ready      (decoded.ready),
    .out_valid      (decoded.valid),
    .out_byte       (decoded.out_byte),
    .repeat_res     (decoded.repeat_res),
    .last_of_run    (decoded.last_of_run)
  );

endmodule

>>> rtl/core/lzrle_checker.sv
// port-level checker for the decoder and its bind to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzrle_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [6:0] repeat_res,
  input logic       last_of_run
);

  // ready drops after each input transfer
  `ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)

  // repeat count stays in its legal range
  `ASSERT_NOW(a_repeat_range, out_valid, repeat_res != 7'd0 && repeat_res <= 7'd65)

  // a run result is always flagged as the last of its run
  `ASSERT_NOW(a_run_is_last, out_valid && repeat_res != 7'd1, last_of_run)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
               out_valid && $stable(out_byte) && $stable(repeat_res) && $stable(last_of_run))

endmodule

bind lz_rle_byte_decompressor_core lzrle_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (compressed.valid),
  .in_ready   (compressed.ready),
  .out_valid  (decoded.valid),
  .out_ready  (decoded.ready),
  .out_byte   (decoded.out_byte),
  .repeat_res (decoded.repeat_res),
  .last_of_run(decoded.last_of_run)
);

>>> tb/lz_rle_byte_decompressor_core_test.sv
// self-checking testbench for the lz/rle byte stream decoder core
`timescale 1ns / 1ps

module lz_rle_byte_decompressor_core_test;

  typedef struct packed {
    logic [7:0] value;
    logic [6:0] count;
    logic       last;
  } sym_t;

  typedef struct packed {
    logic [7:0] b;
    logic       sos;
    logic       typed;
    sym_t       want;
  } step_t;

  typedef enum {TK_LIT, TK_RUN, TK_REF} tok_kind_t;

  localparam sym_t NO_SYM = '0;
  localparam int N_SCRIPT = 26;
  localparam int ITEM_TARGET = 320;
  localparam int CALM_AFTER = 280;

  // literals, short and long runs, overlapping copies, cut-off tokens
  localparam step_t SCRIPT [N_SCRIPT] = '{
    '{8'h00, 1'b1, 1'b0, NO_SYM},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 7'd1, 1'b1}},
    '{8'h01, 1'b0, 1'b0, NO_SYM},
    '{8'hff, 1'b0, 1'b1, '{8'hff, 7'd1, 1'b1}},
    '{8'ha5, 1'b0, 1'b1, '{8'ha5, 7'd1, 1'b1}},
    '{8'h40, 1'b0, 1'b0, NO_SYM},
    '{8'h5a, 1'b0, 1'b1, '{8'h5a, 7'd2, 1'b1}},
    '{8'h7f, 1'b0, 1'b0, NO_SYM},
    '{8'hc3, 1'b0, 1'b1, '{8'hc3, 7'd65, 1'b1}},
    '{8'hff, 1'b0, 1'b0, NO_SYM},
    '{8'hf0, 1'b0, 1'b0, NO_SYM},
    '{8'h02, 1'b0, 1'b0, NO_SYM},
    '{8'h11, 1'b0, 1'b1, '{8'h11, 7'd1, 1'b1}},
    '{8'h22, 1'b0, 1'b1, '{8'h22, 7'd1, 1'b1}},
    '{8'h33, 1'b0, 1'b1, '{8'h33, 7'd1, 1'b1}},
    '{8'hff, 1'b0, 1'b0, NO_SYM},
    '{8'hff, 1'b0, 1'b0, NO_SYM},
    '{8'hff, 1'b0, 1'b0, NO_SYM},
    '{8'hdf, 1'b0, 1'b0, NO_SYM},
    '{8'h05, 1'b0, 1'b0, NO_SYM},
    '{8'h44, 1'b0, 1'b1, '{8'h44, 7'd1, 1'b1}},
    '{8'h40, 1'b1, 1'b0, NO_SYM},
    '{8'h99, 1'b0, 1'b1, '{8'h99, 7'd2, 1'b1}},
    '{8'h90, 1'b0, 1'b0, NO_SYM},
    '{8'h00, 1'b1, 1'b0, NO_SYM},
    '{8'h7e, 1'b0, 1'b1, '{8'h7e, 7'd1, 1'b1}}
  };

  logic clk;
  logic rst;

  lzrle_in_if  cmp_ch ();
  lzrle_out_if dec_ch ();

  lz_rle_byte_decompressor_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .compressed (cmp_ch.sink),
    .decoded    (dec_ch.source)
  );

  // decoder shadow state
  lzrle_pkg::phase_t            phase;
  logic [6:0]                   lit_left;
  logic [7:0]                   tok_hold;
  logic [lzrle_pkg::WIN_AW-1:0] wr_ptr;
  logic [7:0]                   win_mem [lzrle_pkg::WINDOW_DEPTH];
  bit                           win_written [lzrle_pkg::WINDOW_DEPTH];
  bit                           wrap_seen;

  sym_t want_q [$];
  sym_t got, head;

  int  fails;
  int  items_sent;
  int  results_seen;
  int  streams;
  int  later_streams;
  int  n_lit, n_run, n_ref;
  bit  need_sos;
  bit  calm;
  bit  src_busy;
  bit  dst_busy;
  int  dst_gap;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic put_window(input logic [7:0] v);
    win_mem[wr_ptr] = v;
    win_written[wr_ptr] = 1'b1;
    wr_ptr = wr_ptr + 1'b1;
    if (wr_ptr == '0) wrap_seen = 1'b1;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic sos, ref sym_t out_q[$]);
    logic [11:0]                  raw;
    logic [12:0]                  span;
    logic [4:0]                   len;
    logic [6:0]                   cnt;
    logic [lzrle_pkg::WIN_AW-1:0] rd;
    logic [7:0]                   v;
    if (sos) begin
      phase = lzrle_pkg::P_TOKEN;
      lit_left = '0;
      tok_hold = '0;
      wr_ptr = '0;
    end
    case (phase)
      lzrle_pkg::P_TOKEN: begin
        if (b[7]) begin
          tok_hold = b;
          phase = lzrle_pkg::P_REF;
        end else if (!b[6]) begin
          lit_left = 7'(b) + 7'd1;
          phase = lzrle_pkg::P_LIT;
        end else begin
          tok_hold = b;
          phase = lzrle_pkg::P_RUN;
        end
      end
      lzrle_pkg::P_REF: begin
        raw = {tok_hold, b[7:4]};
        span = lzrle_pkg::DIST_BASE - {1'b0, raw};
        len = {1'b0, b[3:0] & lzrle_pkg::LEN_MASK} + 5'd2;
        rd = wr_ptr - lzrle_pkg::WIN_AW'(span);
        for (int i = 0; i < len; i++) begin
          v = win_mem[rd];
          put_window(v);
          rd = rd + 1'b1;
          out_q.insert(out_q.size(), '{v, 7'd1, (i == len - 1)});
        end
        tok_hold = '0;
        phase = lzrle_pkg::P_TOKEN;
      end
      lzrle_pkg::P_LIT: begin
        put_window(b);
        out_q.insert(out_q.size(), '{b, 7'd1, 1'b1});
        if (lit_left != 0) lit_left = lit_left - 7'd1;
        if (lit_left == 0) phase = lzrle_pkg::P_TOKEN;
      end
      default: begin
        cnt = tok_hold[6:0] - lzrle_pkg::RUN_BIAS;
        repeat (cnt) put_window(b);
        out_q.insert(out_q.size(), '{b, cnt, 1'b1});
        tok_hold = '0;
        phase = lzrle_pkg::P_TOKEN;
      end
    endcase
  endtask

  // one compressed byte: optional gap, transfer, then prediction
  task automatic push_byte(input logic [7:0] b, input logic sos, input bit typed,
                           input sym_t want);
    sym_t fresh [$];
    if ($urandom_range(0, 31) == 0) src_busy = !src_busy;
    if (!calm && src_busy && $urandom_range(0, 4) == 0) begin
      cmp_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cmp_ch.valid <= 1'b1;
    cmp_ch.in_byte <= b;
    cmp_ch.start_of_stream <= sos;
    do @(posedge clk); while (!(cmp_ch.valid && cmp_ch.ready));
    decode_byte(b, sos, fresh);
    if (typed) want_q.insert(want_q.size(), want);
    else foreach (fresh[i]) want_q.insert(want_q.size(), fresh[i]);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  task automatic hold_until_drained();
    cmp_ch.valid <= 1'b0;
    do @(posedge clk); while (want_q.size() != 0);
  endtask

  function automatic bit copy_ok(input logic [lzrle_pkg::WIN_AW-1:0] base, input int back,
                                 input int len);
    logic [lzrle_pkg::WIN_AW-1:0] at;
    for (int i = 0; i < len && i < back; i++) begin
      at = base - lzrle_pkg::WIN_AW'(back) + lzrle_pkg::WIN_AW'(i);
      if (!win_written[at]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_token(input bit fill);
    tok_kind_t                    kind;
    int                           n, cnt, back, len, tries, pick;
    logic [15:0]                  word;
    logic [lzrle_pkg::WIN_AW-1:0] base;
    bit                           sos, broken, found;
    sos = need_sos || (wrap_seen && $urandom_range(0, 5) == 0);
    need_sos = 1'b0;
    broken = !fill && $urandom_range(0, 24) == 0;
    if (sos) begin
      streams++;
      if (wrap_seen) later_streams++;
      if ($urandom_range(0, 3) == 0) hold_until_drained();
    end
    pick = $urandom_range(0, 99);
    if (fill) kind = (pick < 85) ? TK_RUN : ((pick < 93) ? TK_REF : TK_LIT);
    else kind = (pick < 35) ? TK_LIT : ((pick < 65) ? TK_RUN : TK_REF);
    back = 2;
    len = 2;
    if (kind == TK_REF) begin
      base = sos ? '0 : wr_ptr;
      found = 1'b0;
      for (tries = 0; tries < 4 && !found; tries++) begin
        case ($urandom_range(0, 3))
          0: back = 2;
          1: back = 2049;
          2: back = $urandom_range(2, 40);
          default: back = $urandom_range(2, 2049);
        endcase
        len = ($urandom_range(0, 3) == 0) ? 17 : $urandom_range(2, 17);
        found = copy_ok(base, back, len);
      end
      if (!found) kind = TK_RUN;
    end
    case (kind)
      TK_LIT: begin
        n = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 6);
        push_byte(8'(n - 1), sos, 1'b0, NO_SYM);
        if (broken) n = $urandom_range(0, n - 1);
        repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_SYM);
        n_lit++;
      end
      TK_RUN: begin
        if (fill) cnt = ($urandom_range(0, 9) < 8) ? 65 : $urandom_range(2, 65);
        else cnt = ($urandom_range(0, 9) < 3) ? 65 : $urandom_range(2, 65);
        push_byte(8'(cnt) + 8'(lzrle_pkg::RUN_BIAS), sos, 1'b0, NO_SYM);
        if (!broken) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_SYM);
        n_run++;
      end
      default: begin
        word = {12'(lzrle_pkg::DIST_BASE - 13'(back)), 4'(len - 2)};
        push_byte(word[15:8], sos, 1'b0, NO_SYM);
        if (!broken) push_byte(word[7:0], 1'b0, 1'b0, NO_SYM);
        n_ref++;
      end
    endcase
    if (broken) need_sos = 1'b1;
  endtask

  // output side: random stall bursts, checked against the oldest expectation
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) dst_busy <= !dst_busy;
    if (dst_gap != 0) begin
      dst_gap <= dst_gap - 1;
      dec_ch.ready <= 1'b0;
    end else if (!calm && dst_busy && $urandom_range(0, 5) == 0) begin
      dst_gap <= $urandom_range(0, 6);
      dec_ch.ready <= 1'b0;
    end else begin
      dec_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && dec_ch.valid && dec_ch.ready) begin
      got = '{dec_ch.out_byte, dec_ch.repeat_res, dec_ch.last_of_run};
      results_seen++;
      if (want_q.size() == 0) begin
        fails++;
        if (fails <= 20)
          $display("%0t: unexpected result byte=%02h rep=%0d last=%0b", $time,
                   got.value, got.count, got.last);
      end else begin
        head = want_q.pop_front();
        if (got !== head) begin
          fails++;
          if (fails <= 20)
            $display("%0t: mismatch expected byte=%02h rep=%0d last=%0b, got byte=%02h rep=%0d last=%0b",
                     $time, head.value, head.count, head.last,
                     got.value, got.count, got.last);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cmp_ch.valid = 1'b0;
    cmp_ch.in_byte = '0;
    cmp_ch.start_of_stream = 1'b0;
    dec_ch.ready = 1'b0;
    phase = lzrle_pkg::P_TOKEN;
    lit_left = '0;
    tok_hold = '0;
    wr_ptr = '0;
    wrap_seen = 1'b0;
    fails = 0;
    items_sent = 0;
    results_seen = 0;
    streams = 0;
    later_streams = 0;
    n_lit = 0;
    n_run = 0;
    n_ref = 0;
    need_sos = 1'b1;
    calm = 1'b0;
    src_busy = 1'b1;
    dst_busy = 1'b1;
    dst_gap = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (SCRIPT[i])
      push_byte(SCRIPT[i].b, SCRIPT[i].sos, SCRIPT[i].typed, SCRIPT[i].want);
    hold_until_drained();

    // fill the window past a wrap first, then mixed streams
    while (!(items_sent >= ITEM_TARGET && wrap_seen && later_streams >= 2))
      send_token(!wrap_seen);

    cmp_ch.valid <= 1'b0;
    do @(posedge clk); while (want_q.size() != 0);
    repeat (80) @(posedge clk);

    $display("covered %0d compressed bytes and %0d decoded results over %0d streams",
             items_sent, results_seen, streams);
    $display("random tokens: %0d literal, %0d run, %0d copy; window wrapped: %0b",
             n_lit, n_run, n_ref, wrap_seen);
    if (fails == 0) begin
      $display("lz_rle_byte_decompressor_core regression: pass");
    end else begin
      $display("lz_rle_byte_decompressor_core regression: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", want_q.size());
    $display("lz_rle_byte_decompressor_core regression: fail");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lzrle_pkg.sv
rtl/core/lzrle_if.sv
rtl/core/lzrle_ram.sv
rtl/core/lzrle_ctrl.sv
rtl/core/lzrle_datapath.sv
rtl/core/lz_rle_byte_decompressor_core.sv
rtl/core/lzrle_checker.sv
tb/lz_rle_byte_decompressor_core_test.sv
